/* design/mis_pkg.sv */
package mis_pkg;

	// Fixed-point layout of the step register and the accumulator
	localparam int STEP_BITS = 21;
	localparam int ACC_BITS  = 22;
	localparam int FRAC_BITS = 16;
	localparam logic signed [ACC_BITS-1:0] ONE_Q16 = ACC_BITS'(1 << FRAC_BITS);
	localparam logic signed [ACC_BITS-1:0] MINUS_ONE_Q16 = -ONE_Q16;

	// Cap on results caused by one input
	localparam int MAX_RESULTS = 48;
	localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP          = 2'd2;

	// Item classification made by the front end
	typedef struct packed {
		logic first;
		logic last;
	} item_flags_t;

	// Back end sequencer
	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_PAD
	} back_state_t;

endpackage

/* design/mis_front.sv */
module mis_front #(
	parameter int LENGTH_BITS = 16,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic        [LENGTH_BITS-1:0] source_length,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] wrap_sample,
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic signed [SAMPLE_BITS-1:0] q_sample,
	output logic signed [SAMPLE_BITS-1:0] q_other,
	output mis_pkg::item_flags_t          q_flags
);

	logic        [LENGTH_BITS-1:0] inputs_taken_q;
	logic signed [SAMPLE_BITS-1:0] previous_q;
	logic        [LENGTH_BITS-1:0] src_len;
	logic                          accept;

	// Zero source length counts as one
	assign src_len = (source_length == '0) ? LENGTH_BITS'(1) : source_length;

	// Classify the incoming item
	always_comb begin
		q_flags.first = (inputs_taken_q == '0);
		q_flags.last  = (({1'b0, inputs_taken_q} + (LENGTH_BITS+1)'(1)) >= {1'b0, src_len});
		q_other       = q_flags.first ? wrap_sample : previous_q;
	end

	assign q_valid  = in_valid;
	assign q_sample = sample;
	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;

	// Sequence position and previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inputs_taken_q <= '0;
			previous_q     <= '0;
		end else if (accept) begin
			if (q_flags.last) begin
				inputs_taken_q <= '0;
				previous_q     <= '0;
			end else begin
				inputs_taken_q <= inputs_taken_q + LENGTH_BITS'(1);
				previous_q     <= sample;
			end
		end
	end

endmodule

/* design/mis_queue.sv */
module mis_queue #(
	parameter int WIDTH = 66
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	// Two-entry queue between front and back
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/mis_back.sv */
module mis_back #(
	parameter int LENGTH_BITS = 16,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic        [LENGTH_BITS-1:0]         source_length,
	input  logic        [LENGTH_BITS-1:0]         target_length,
	input  logic signed [mis_pkg::STEP_BITS-1:0]  step,
	input  logic                                  q_valid,
	output logic                                  q_ready,
	input  logic signed [SAMPLE_BITS-1:0]         q_sample,
	input  logic signed [SAMPLE_BITS-1:0]         q_other,
	input  mis_pkg::item_flags_t                  q_flags,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]         value,
	output logic                                  item_last,
	output logic                                  sequence_end
);

	mis_pkg::back_state_t state_q, state_d;

	// Current item
	logic signed [SAMPLE_BITS-1:0]        sample_q;
	logic signed [SAMPLE_BITS-1:0]        other_q;
	mis_pkg::item_flags_t                 flags_q;

	// Sequence state
	logic signed [mis_pkg::ACC_BITS-1:0]  acc_q;
	logic        [LENGTH_BITS-1:0]        given_q;
	logic        [mis_pkg::CNT_BITS-1:0]  n_q;

	// Output register
	logic                                 out_valid_q;
	logic signed [SAMPLE_BITS-1:0]        value_q;
	logic                                 item_last_q;
	logic                                 seq_end_q;

	logic        [LENGTH_BITS-1:0]        src_len;
	logic        [LENGTH_BITS-1:0]        total;
	logic signed [mis_pkg::ACC_BITS-1:0]  step_ext;
	logic signed [mis_pkg::ACC_BITS-1:0]  acc_sum;
	logic signed [mis_pkg::ACC_BITS-1:0]  acc_clamped;
	logic signed [SAMPLE_BITS:0]          mid_sum;
	logic signed [SAMPLE_BITS-1:0]        mid;
	logic                                 can_emit;
	logic                                 hits_total;
	logic                                 hits_cap;
	logic                                 is_mid;
	logic                                 out_free;
	logic                                 pop;
	logic                                 emit;
	logic                                 advance;
	logic signed [SAMPLE_BITS-1:0]        res_value;
	logic                                 res_last;
	logic                                 res_end;

	// Sequence length and emit limits
	always_comb begin
		src_len    = (source_length == '0) ? LENGTH_BITS'(1) : source_length;
		total      = (target_length > src_len) ? target_length : src_len;
		can_emit   = (given_q < total) && (n_q < mis_pkg::CNT_BITS'(mis_pkg::MAX_RESULTS));
		hits_total = (({1'b0, given_q} + (LENGTH_BITS+1)'(1)) == {1'b0, total});
		hits_cap   = (n_q == mis_pkg::CNT_BITS'(mis_pkg::MAX_RESULTS - 1));
	end

	// Accumulator arithmetic
	always_comb begin
		step_ext = {{(mis_pkg::ACC_BITS - mis_pkg::STEP_BITS){step[mis_pkg::STEP_BITS-1]}}, step};
		acc_sum  = acc_q + step_ext;
		acc_clamped = (acc_sum < mis_pkg::MINUS_ONE_Q16) ? mis_pkg::MINUS_ONE_Q16 : acc_sum;
		is_mid   = (acc_q >= mis_pkg::ONE_Q16);
	end

	// Midpoint: sum shifted right by one, rounding toward minus infinity
	assign mid_sum = {other_q[SAMPLE_BITS-1], other_q} + {sample_q[SAMPLE_BITS-1], sample_q};
	assign mid     = mid_sum[SAMPLE_BITS:1];

	assign out_free = !out_valid_q || out_ready;
	assign pop      = q_valid && q_ready;

	// Per-cycle actions and result fields
	always_comb begin
		q_ready   = 1'b0;
		emit      = 1'b0;
		advance   = 1'b0;
		res_value = '0;
		res_last  = 1'b0;
		res_end   = 1'b0;
		case (state_q)
			mis_pkg::S_IDLE: begin
				q_ready = 1'b1;
			end
			mis_pkg::S_RUN: begin
				advance   = !can_emit || out_free;
				emit      = can_emit && out_free;
				res_value = is_mid ? mid : sample_q;
				res_last  = hits_total || hits_cap || (!is_mid && !flags_q.last);
				res_end   = hits_total || (flags_q.last && res_last);
			end
			mis_pkg::S_PAD: begin
				advance   = !can_emit || out_free;
				emit      = can_emit && out_free;
				res_value = '0;
				res_last  = hits_total || hits_cap;
				res_end   = res_last;
			end
			default: begin
				q_ready = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mis_pkg::S_IDLE: begin
				if (q_valid) begin
					state_d = mis_pkg::S_RUN;
				end
			end
			mis_pkg::S_RUN: begin
				if (advance && !is_mid) begin
					state_d = flags_q.last ? mis_pkg::S_PAD : mis_pkg::S_IDLE;
				end
			end
			mis_pkg::S_PAD: begin
				if (!can_emit) begin
					state_d = mis_pkg::S_IDLE;
				end
			end
			default: state_d = mis_pkg::S_IDLE;
		endcase
	end

	// Item registers
	always_ff @(posedge clk) begin
		if (pop) begin
			sample_q <= q_sample;
			other_q  <= q_other;
		end
	end

	// Control and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mis_pkg::S_IDLE;
			flags_q <= '0;
			acc_q   <= '0;
			given_q <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				flags_q <= q_flags;
				n_q     <= '0;
				if (q_flags.first) begin
					acc_q <= step_ext;
				end
			end
			if (state_q == mis_pkg::S_RUN && advance) begin
				acc_q <= is_mid ? (acc_q - mis_pkg::ONE_Q16) : acc_clamped;
			end
			if (emit) begin
				given_q <= given_q + LENGTH_BITS'(1);
				n_q     <= n_q + mis_pkg::CNT_BITS'(1);
			end
			if (state_q == mis_pkg::S_PAD && !can_emit) begin
				given_q <= '0;
			end
		end
	end

	// Output register, loads when empty or while the previous result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q     <= res_value;
			item_last_q <= res_last;
			seq_end_q   <= res_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign item_last    = item_last_q;
	assign sequence_end = seq_end_q;

	// Per-input result count never passes the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= mis_pkg::CNT_BITS'(mis_pkg::MAX_RESULTS))
		else $error("result count above cap");

	// The end of a sequence is always the end of its input
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && seq_end_q |-> item_last_q)
		else $error("sequence_end without item_last");

	// Padding only follows the last input of a sequence
	a_pad_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mis_pkg::S_PAD |-> flags_q.last)
		else $error("padding on a non-final input");

endmodule

/* design/midpoint_insertion_stretcher_core.sv */
// Midpoint insertion stretcher.
// Input channel (in_valid/in_ready) takes one Q16.16 sample per transfer, with
// the wrap sample used for the first input of each sequence. Output channel
// (out_valid/out_ready) gives one result per transfer: value, item_last on the
// final result of an input, sequence_end on the final result of a sequence.
// Configuration (cfg_we, cfg_index, cfg_data) writes source_length,
// target_length and step; write only while the block is idle.
// The front end classifies inputs and pushes them into a two-entry queue, so
// inputs keep flowing while the back end works. For each item the back end
// sequencer first takes it from the queue, then gives one midpoint per whole
// unit of the accumulator (up to 16 for the largest step) and then the sample;
// the last input of a sequence adds padding zeros up to the 48-result cap. The
// first result of an input passes through the queue, the item registers and
// the output register.
// A stalled receiver holds the output register; the sequencer and then the
// queue fill, after which in_ready drops. Reset clears the sequence position,
// the queue and the output, and sets the registers to source and target
// length 1 and step 0.
module midpoint_insertion_stretcher_core #(
	parameter int LENGTH_BITS = 16,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mis_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [((LENGTH_BITS > mis_pkg::STEP_BITS) ? LENGTH_BITS
	              : mis_pkg::STEP_BITS)-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	input  logic signed [SAMPLE_BITS-1:0]          wrap_sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [SAMPLE_BITS-1:0]          value,
	output logic                                   item_last,
	output logic                                   sequence_end
);

	localparam int FLAG_BITS  = $bits(mis_pkg::item_flags_t);
	localparam int ITEM_BITS  = 2 * SAMPLE_BITS + FLAG_BITS;

	logic        [LENGTH_BITS-1:0]         source_length_q;
	logic        [LENGTH_BITS-1:0]         target_length_q;
	logic signed [mis_pkg::STEP_BITS-1:0]  step_q;

	logic                                  push_valid;
	logic                                  push_ready;
	logic signed [SAMPLE_BITS-1:0]         push_sample;
	logic signed [SAMPLE_BITS-1:0]         push_other;
	mis_pkg::item_flags_t                  push_flags;
	logic        [ITEM_BITS-1:0]           push_data;

	logic                                  pop_valid;
	logic                                  pop_ready;
	logic        [ITEM_BITS-1:0]           pop_data;
	logic signed [SAMPLE_BITS-1:0]         pop_sample;
	logic signed [SAMPLE_BITS-1:0]         pop_other;
	mis_pkg::item_flags_t                  pop_flags;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_length_q <= LENGTH_BITS'(1);
			target_length_q <= LENGTH_BITS'(1);
			step_q          <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mis_pkg::CFG_SOURCE_LENGTH: source_length_q <= cfg_data[LENGTH_BITS-1:0];
				mis_pkg::CFG_TARGET_LENGTH: target_length_q <= cfg_data[LENGTH_BITS-1:0];
				mis_pkg::CFG_STEP:          step_q <= cfg_data[mis_pkg::STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	mis_front #(
		.LENGTH_BITS (LENGTH_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_length (source_length_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.wrap_sample   (wrap_sample),
		.q_valid       (push_valid),
		.q_ready       (push_ready),
		.q_sample      (push_sample),
		.q_other       (push_other),
		.q_flags       (push_flags)
	);

	assign push_data = {push_flags, push_other, push_sample};

	mis_queue #(
		.WIDTH (ITEM_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_sample = pop_data[SAMPLE_BITS-1:0];
	assign pop_other  = pop_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign pop_flags  = pop_data[ITEM_BITS-1:2*SAMPLE_BITS];

	mis_back #(
		.LENGTH_BITS (LENGTH_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_length (source_length_q),
		.target_length (target_length_q),
		.step          (step_q),
		.q_valid       (pop_valid),
		.q_ready       (pop_ready),
		.q_sample      (pop_sample),
		.q_other       (pop_other),
		.q_flags       (pop_flags),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.value         (value),
		.item_last     (item_last),
		.sequence_end  (sequence_end)
	);

endmodule
